>>> hdl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }

    // Bracket kinds
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_CURLY  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_MATCHED         = 3'd1;
    localparam logic [2:0] ST_MISMATCH        = 3'd2;
    localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd3;
    localparam logic [2:0] ST_UNCLOSED        = 3'd4;
    localparam logic [2:0] ST_OVERFLOW        = 3'd5;

    // Decoded operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       final_res;
        logic [6:0] nesting_depth;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/bbc_front.sv
`default_nettype none

module bbc_front
    import bbc_pkg::*;
(
    input  wire in_item_t s_item,
    output cmd_t          cmd
);

    // Classify the byte into open / close / other with its bracket kind
    always_comb begin
        cmd.last = s_item.end_of_string;
        cmd.op   = OP_NONE;
        cmd.kind = KIND_ROUND;
        case (s_item.char_code)
            CH_OPEN_ROUND: begin
                cmd.op   = OP_OPEN;
                cmd.kind = KIND_ROUND;
            end
            CH_OPEN_CURLY: begin
                cmd.op   = OP_OPEN;
                cmd.kind = KIND_CURLY;
            end
            CH_OPEN_SQUARE: begin
                cmd.op   = OP_OPEN;
                cmd.kind = KIND_SQUARE;
            end
            CH_CLOSE_ROUND: begin
                cmd.op   = OP_CLOSE;
                cmd.kind = KIND_ROUND;
            end
            CH_CLOSE_CURLY: begin
                cmd.op   = OP_CLOSE;
                cmd.kind = KIND_CURLY;
            end
            CH_CLOSE_SQUARE: begin
                cmd.op   = OP_CLOSE;
                cmd.kind = KIND_SQUARE;
            end
            default: begin
                cmd.op   = OP_NONE;
                cmd.kind = KIND_ROUND;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/bbc_fifo.sv
`default_nettype none

module bbc_fifo
    import bbc_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        wr_valid,
    output logic       wr_ready,
    input  wire cmd_t  wr_cmd,
    output logic       rd_valid,
    input  wire        rd_ready,
    output cmd_t       rd_cmd
);

    // Two-entry queue between decode and stack execution
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bbc_back.sv
`default_nettype none

module bbc_back
    import bbc_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd,
    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_item
);

    // Kind stack memory with a registered read of the current top entry
    logic [1:0]        kind_mem [STACK_DEPTH];
    logic [1:0]        rd_data_reg;
    logic              byp_reg;
    logic [1:0]        byp_kind_reg;
    logic [1:0]        top_kind;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        err_reg, err_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic              fire;
    logic              push;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  cnt_step;
    logic [CNT_W-1:0]  top_idx;
    logic [2:0]        status;

    assign fire      = cmd_valid && (!m_valid_reg || m_ready);
    assign cmd_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign top_kind  = byp_reg ? byp_kind_reg : rd_data_reg;

    // Execute one command against the stack
    always_comb begin
        cnt_step    = count_reg;
        err_next    = err_reg;
        push        = 1'b0;
        wr_addr     = ADDR_W'(count_reg);
        status      = ST_OK;
        m_item_next = m_item_reg;
        if (err_reg == ST_OK) begin
            case (cmd.op)
                OP_OPEN: begin
                    if (count_reg == CNT_W'(STACK_DEPTH)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        push     = 1'b1;
                        cnt_step = count_reg + CNT_W'(1);
                    end
                end
                OP_CLOSE: begin
                    if (count_reg == '0) begin
                        err_next = ST_UNMATCHED_CLOSE;
                    end else begin
                        cnt_step = count_reg - CNT_W'(1);
                        if (top_kind == cmd.kind) begin
                            status = ST_MATCHED;
                        end else begin
                            err_next = ST_MISMATCH;
                        end
                    end
                end
                default: begin
                    cnt_step = count_reg;
                end
            endcase
        end
        if (err_next != ST_OK) begin
            status = err_next;
        end
        m_item_next.nesting_depth = 7'(cnt_step);
        m_item_next.final_res     = cmd.last;
        count_next                = cnt_step;
        // End of string: verdict, then clear for the next string
        if (cmd.last) begin
            if (err_next != ST_OK) begin
                status = err_next;
            end else if (cnt_step != '0) begin
                status = ST_UNCLOSED;
            end else begin
                status = ST_MATCHED;
            end
            count_next = '0;
            err_next   = ST_OK;
        end
        m_item_next.status = status;
        if (!fire) begin
            count_next  = count_reg;
            err_next    = err_reg;
            push        = 1'b0;
            m_item_next = m_item_reg;
        end
    end

    // Top entry sits at count-1 after this cycle
    assign top_idx = count_next - CNT_W'(1);
    assign rd_addr = ADDR_W'(top_idx);

    // Output valid tracking
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
            byp_reg     <= push;
        end
    end

    // Payload registers and stack memory
    always_ff @(posedge aclk) begin
        m_item_reg   <= m_item_next;
        byp_kind_reg <= cmd.kind;
        rd_data_reg  <= kind_mem[rd_addr];
        if (push) begin
            kind_mem[wr_addr] <= cmd.kind;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bracket_balance_checker.sv
// Bracket balance checker.
// Input channel s_valid/s_ready/s_item carries one byte of a string per item,
// with end_of_string marking the last byte. Opening brackets ( { [ are pushed,
// closing brackets pop and compare; other bytes are ignored. The first error
// of a string is latched and the rest of that string changes nothing.
// Result channel m_valid/m_ready/m_item returns one item per input item:
// status, final_res (set on the last byte, then status is the verdict) and
// the nesting depth after the byte.
// Throughput: one item per cycle while m_ready stays high. An accepted item
// is stored in the queue, then executed by the stack unit with its result
// captured in the output register. The stack top is read through a registered
// memory port with a bypass for the entry just pushed, so pushes and pops can
// follow each other every cycle.
// A two-entry queue sits between the byte decoder and the stack unit, and
// the result sits in an output register. When m_ready is low the result
// holds, the queue fills, and s_ready drops once it is full.
// Reset (aresetn low, synchronous) empties the queue and output, clears the
// stack count and the latched error. Stack contents need no clearing.
`default_nettype none

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire            m_ready,
    output out_item_t      m_item
);

    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    // Front: decode bytes
    bbc_front u_front (
        .s_item (s_item),
        .cmd    (dec_cmd)
    );

    // Queue between front and back
    bbc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_cmd   (dec_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    // Back: stack execution and result register
    bbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

>>> sim/bracket_balance_checker_tb.sv
module bracket_balance_checker_tb;
    import bbc_pkg::*;

    localparam int RANDOM_ITEMS   = 1900;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_ROWS  = 24;

    // One row of the directed table: the byte, whether the result is typed in, and that result
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } char_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predictor state
    logic [1:0] kind_mem [STACK_DEPTH];
    int         open_count;
    logic [2:0] held_error;

    out_item_t  verdict_q [$];
    in_item_t   text_q [$];
    int         sent_count;
    int         burst_left;
    int         result_count;
    int         fail_count;
    int         idle_cycles;
    bit         hold_off_req;

    char_row_t directed_rows [DIRECTED_ROWS] = '{
        // bracket-free single-byte string is balanced
        {8'h00,           1'b1, 1'b1, ST_MATCHED,         1'b1, 7'd0},
        {8'hFF,           1'b0, 1'b1, ST_OK,              1'b0, 7'd0},
        {CH_OPEN_ROUND,   1'b0, 1'b1, ST_OK,              1'b0, 7'd1},
        {CH_CLOSE_ROUND,  1'b0, 1'b1, ST_MATCHED,         1'b0, 7'd0},
        // kind mismatch pops, then the rest of the string is ignored
        {CH_OPEN_CURLY,   1'b0, 1'b1, ST_OK,              1'b0, 7'd1},
        {CH_CLOSE_SQUARE, 1'b0, 1'b1, ST_MISMATCH,        1'b0, 7'd0},
        {CH_OPEN_ROUND,   1'b0, 1'b1, ST_MISMATCH,        1'b0, 7'd0},
        {8'h00,           1'b1, 1'b1, ST_MISMATCH,        1'b1, 7'd0},
        // close on an empty stack
        {CH_CLOSE_CURLY,  1'b0, 1'b1, ST_UNMATCHED_CLOSE, 1'b0, 7'd0},
        {CH_CLOSE_ROUND,  1'b1, 1'b1, ST_UNMATCHED_CLOSE, 1'b1, 7'd0},
        // nested, with noise inside
        {CH_OPEN_SQUARE,  1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_OPEN_CURLY,   1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {8'hAA,           1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_CLOSE_CURLY,  1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_CLOSE_SQUARE, 1'b1, 1'b1, ST_MATCHED,         1'b1, 7'd0},
        // left open at the end, plus a close on an empty stack after noise
        {CH_OPEN_ROUND,   1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_OPEN_SQUARE,  1'b1, 1'b1, ST_UNCLOSED,        1'b1, 7'd2},
        {8'h55,           1'b0, 1'b1, ST_OK,              1'b0, 7'd0},
        {CH_CLOSE_ROUND,  1'b1, 1'b1, ST_UNMATCHED_CLOSE, 1'b1, 7'd0},
        {CH_OPEN_CURLY,   1'b1, 1'b1, ST_UNCLOSED,        1'b1, 7'd1},
        // mismatch on the last byte, then a balanced pair
        {CH_OPEN_SQUARE,  1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_CLOSE_ROUND,  1'b1, 1'b1, ST_MISMATCH,        1'b1, 7'd0},
        {CH_OPEN_ROUND,   1'b0, 1'b0, ST_OK,              1'b0, 7'd0},
        {CH_CLOSE_ROUND,  1'b1, 1'b1, ST_MATCHED,         1'b1, 7'd0}
    };

    bracket_balance_checker u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bracket byte helpers
    function automatic logic [7:0] open_char(logic [1:0] kind);
        case (kind)
            KIND_ROUND: return CH_OPEN_ROUND;
            KIND_CURLY: return CH_OPEN_CURLY;
            default:    return CH_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(logic [1:0] kind);
        case (kind)
            KIND_ROUND: return CH_CLOSE_ROUND;
            KIND_CURLY: return CH_CLOSE_CURLY;
            default:    return CH_CLOSE_SQUARE;
        endcase
    endfunction

    function automatic bit is_closer(logic [7:0] ch);
        return ch == CH_CLOSE_ROUND || ch == CH_CLOSE_CURLY || ch == CH_CLOSE_SQUARE;
    endfunction

    function automatic bit is_bracket(logic [7:0] ch);
        return is_closer(ch) || ch == CH_OPEN_ROUND || ch == CH_OPEN_CURLY
            || ch == CH_OPEN_SQUARE;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_bracket(b));
        return b;
    endfunction

    function automatic logic [1:0] any_kind();
        return 2'($urandom_range(0, 2));
    endfunction

    // Bracket matcher: advances the predictor state by one byte, returns its status item
    function automatic out_item_t bracket_step(in_item_t it);
        out_item_t  r;
        bit         opener;
        bit         closer;
        logic [1:0] kind;
        r        = '0;
        opener   = 1'b0;
        closer   = 1'b0;
        kind     = KIND_ROUND;
        r.status = ST_OK;
        case (it.char_code)
            CH_OPEN_ROUND:   begin opener = 1'b1; kind = KIND_ROUND;  end
            CH_OPEN_CURLY:   begin opener = 1'b1; kind = KIND_CURLY;  end
            CH_OPEN_SQUARE:  begin opener = 1'b1; kind = KIND_SQUARE; end
            CH_CLOSE_ROUND:  begin closer = 1'b1; kind = KIND_ROUND;  end
            CH_CLOSE_CURLY:  begin closer = 1'b1; kind = KIND_CURLY;  end
            CH_CLOSE_SQUARE: begin closer = 1'b1; kind = KIND_SQUARE; end
            default: ;
        endcase
        if (held_error == ST_OK) begin
            if (opener) begin
                if (open_count >= STACK_DEPTH) begin
                    held_error = ST_OVERFLOW;
                end else begin
                    kind_mem[open_count] = kind;
                    open_count++;
                end
            end else if (closer) begin
                if (open_count == 0) begin
                    held_error = ST_UNMATCHED_CLOSE;
                end else begin
                    open_count--;
                    if (kind_mem[open_count] == kind)
                        r.status = ST_MATCHED;
                    else
                        held_error = ST_MISMATCH;
                end
            end
        end
        if (held_error != ST_OK)
            r.status = held_error;
        r.nesting_depth = 7'(open_count);
        r.final_res     = it.end_of_string;
        // verdict for the whole string, then clear for the next one
        if (it.end_of_string) begin
            if (held_error != ST_OK)
                r.status = held_error;
            else if (open_count != 0)
                r.status = ST_UNCLOSED;
            else
                r.status = ST_MATCHED;
            open_count = 0;
            held_error = ST_OK;
        end
        return r;
    endfunction

    // Offer one item in bursts with random gaps; record its verdict once accepted
    task automatic send_char(in_item_t it, logic typed, out_item_t want);
        out_item_t pred;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = bracket_step(it);
        verdict_q.push_back(typed ? want : pred);
        sent_count++;
    endtask

    task automatic send_string();
        if (text_q.size() == 0)
            text_q.push_back({noise_byte(), 1'b0});
        text_q[text_q.size() - 1].end_of_string = 1'b1;
        foreach (text_q[i])
            send_char(text_q[i], 1'b0, '0);
        text_q.delete();
    endtask

    // n opens of random kinds, then the matching closes in reverse
    task automatic append_deep(int n);
        logic [1:0] kinds [$];
        repeat (n) begin
            kinds.push_back(any_kind());
            text_q.push_back({open_char(kinds[kinds.size() - 1]), 1'b0});
        end
        while (kinds.size() != 0)
            text_q.push_back({close_char(kinds.pop_back()), 1'b0});
    endtask

    // Random string; mostly well-formed with noise, the rest broken in various ways
    task automatic build_string(int sel);
        logic [1:0] kinds [$];
        int         len;
        int         r;
        int         idx;
        int         closers [$];
        logic [7:0] c;
        if (sel < 70) begin
            len = $urandom_range(1, 24);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    text_q.push_back({noise_byte(), 1'b0});
                end else if (kinds.size() == 0 || r < 60) begin
                    kinds.push_back(any_kind());
                    text_q.push_back({open_char(kinds[kinds.size() - 1]), 1'b0});
                end else begin
                    text_q.push_back({close_char(kinds.pop_back()), 1'b0});
                end
            end
            if ($urandom_range(0, 99) >= 15) begin
                while (kinds.size() != 0)
                    text_q.push_back({close_char(kinds.pop_back()), 1'b0});
            end
            // inject a wrong closer into some of them
            if (sel >= 55) begin
                foreach (text_q[i])
                    if (is_closer(text_q[i].char_code))
                        closers.push_back(i);
                if (closers.size() != 0) begin
                    idx = closers[$urandom_range(0, closers.size() - 1)];
                    do c = close_char(any_kind()); while (c == text_q[idx].char_code);
                    text_q[idx].char_code = c;
                end
            end
        end else if (sel < 85) begin
            len = $urandom_range(1, 16);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    text_q.push_back({noise_byte(), 1'b0});
                else if (r < 65)
                    text_q.push_back({open_char(any_kind()), 1'b0});
                else
                    text_q.push_back({close_char(any_kind()), 1'b0});
            end
        end else if (sel < 93) begin
            text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
        end else begin
            append_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4));
        end
    endtask

    // Stimulus
    initial begin
        bit second_hold;
        second_hold  = 1'b0;
        open_count   = 0;
        held_error   = ST_OK;
        sent_count   = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // start the random part with a long receiver hold-off and an overflowing string
        hold_off_req = 1'b1;
        append_deep(STACK_DEPTH + 2);
        send_string();
        text_q.push_back({CH_OPEN_ROUND, 1'b0});
        append_deep(STACK_DEPTH - 1);
        send_string();

        while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            build_string($urandom_range(0, 99));
            send_string();
            if (!second_hold && sent_count > 1000) begin
                second_hold  = 1'b1;
                hold_off_req = 1'b1;
            end
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("bracket_balance_checker test passed");
        else
            $display("bracket_balance_checker test failed");
        $finish;
    end

    // Receiver: own stall pattern, plus a long hold-off on request
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        m_ready <= 1'b1;
                        repeat ($urandom_range(10, 60)) @(posedge aclk);
                    end
                    1: begin
                        m_ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge aclk);
                    end
                    default: begin
                        repeat ($urandom_range(5, 30)) begin
                            m_ready <= ($urandom_range(0, 2) != 0);
                            @(posedge aclk);
                        end
                    end
                endcase
            end
        end
    end

    // Result check and watchdog
    initial begin
        result_count = 0;
        fail_count   = 0;
        idle_cycles  = 0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d unexpected: status=%0d final=%0d depth=%0d",
                             result_count, m_item.status, m_item.final_res,
                             m_item.nesting_depth);
            end else begin
                want = verdict_q.pop_front();
                if (m_item.status !== want.status || m_item.final_res !== want.final_res
                    || m_item.nesting_depth !== want.nesting_depth) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d: expected status=%0d final=%0d depth=%0d, %s%0d %s%0d %s%0d",
                                 result_count, want.status, want.final_res,
                                 want.nesting_depth, "got status=", m_item.status,
                                 "final=", m_item.final_res, "depth=",
                                 m_item.nesting_depth);
                end
            end
            result_count++;
        end

        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("bracket_balance_checker test failed");
            $finish;
        end
    end

endmodule

>>> bracket_balance_checker.f
hdl/bbc_pkg.sv
hdl/bbc_front.sv
hdl/bbc_fifo.sv
hdl/bbc_back.sv
hdl/bracket_balance_checker.sv
sim/bracket_balance_checker_tb.sv
